@@ src/csw_pkg.sv @@
// shared types, character codes and helpers for the comment and whitespace skipper
// no dependencies
`default_nettype none

package csw_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int OUT_COUNT_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_COMMENT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_COMMENT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTINUATION  = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_BSL   = 8'h5C;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [OUT_COUNT_WIDTH-1:0] skipped_count;
      logic [OUT_COUNT_WIDTH-1:0] line_count;
   } rsp_type;

   typedef struct packed {
      logic line_comment_enable;
      logic block_comment_enable;
      logic continuation_enable;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   typedef enum logic [7:0] {
      M_WS      = 8'b0000_0001,
      M_SLASH   = 8'b0000_0010,
      M_LINE    = 8'b0000_0100,
      M_BLOCK   = 8'b0000_1000,
      M_BSTAR   = 8'b0001_0000,
      M_BSL     = 8'b0010_0000,
      M_BSLCR   = 8'b0100_0000,
      M_DISCARD = 8'b1000_0000
   } scan_mode_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
             (c == CH_VT) || (c == CH_FF);
   endfunction

endpackage

`default_nettype wire

@@ src/comment_whitespace_skipper_unit.sv @@
// top level: enable registers, input register, scan core, result register
// depends on csw_pkg, csw_in_stage, csw_scan_core, csw_out_stage
// byte path: input register, combinational scan core, result register
// throughput: one byte per cycle unless a waiting result stalls the scan state update
// the input register keeps accepting while a result waits, until both registers are full
// synchronous reset: enables return to 1, scan restarts at buffer start with zero counts
`default_nettype none

module comment_whitespace_skipper_unit #(
   parameter int COUNT_WIDTH = csw_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire csw_pkg::req_type                       req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output csw_pkg::rsp_type                            rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [csw_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [csw_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import csw_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       drain, step;
   req_type    item;
   result_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_COMMENT:  cfg_in.line_comment_enable  = csr_wdata[0];
            CSR_BLOCK_COMMENT: cfg_in.block_comment_enable = csr_wdata[0];
            CSR_CONTINUATION:  cfg_in.continuation_enable  = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{line_comment_enable: 1'b1, block_comment_enable: 1'b1,
                     continuation_enable: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   csw_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .drain     (drain),
      .step      (step),
      .item      (item)
   );

   csw_scan_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   csw_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .drain     (drain),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ src/csw_in_stage.sv @@
// input register for one text item
// depends on csw_pkg
`default_nettype none

module csw_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire csw_pkg::req_type req_data,
   input  wire logic             drain,
   output logic                  step,
   output csw_pkg::req_type      item
);
   import csw_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   assign step      = valid_ff && drain;
   assign req_ready = !valid_ff || drain;
   assign item      = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

@@ src/csw_scan_core.sv @@
// scan state machine with committed and tentative counts
// depends on csw_pkg
`default_nettype none

module csw_scan_core #(
   parameter int COUNT_WIDTH = csw_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire csw_pkg::req_type    item,
   input  wire csw_pkg::cfg_type    cfg,
   output csw_pkg::result_type      result
);
   import csw_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] ONE   = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] TWO   = COUNT_WIDTH'(2);
   localparam logic [COUNT_WIDTH-1:0] THREE = COUNT_WIDTH'(3);

   function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_COUNT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
      logic [COUNT_WIDTH+OUT_COUNT_WIDTH-1:0] wide;
      wide = {{OUT_COUNT_WIDTH{1'b0}}, v};
      return wide[OUT_COUNT_WIDTH-1:0];
   endfunction

   scan_mode_type          mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0] cb_ff, cb_in, cn_ff, cn_in, tb_ff, tb_in, tn_ff, tn_in;
   logic [COUNT_WIDTH-1:0] tb_inc;
   logic                   emit, end_check;
   logic [7:0]             c;
   logic                   last;

   assign c      = item.text_byte;
   assign last   = item.is_last;
   assign tb_inc = sat_add(tb_ff, ONE);

   always_comb begin
      mode_in   = mode_ff;
      cb_in     = cb_ff;
      cn_in     = cn_ff;
      tb_in     = tb_ff;
      tn_in     = tn_ff;
      emit      = 1'b0;
      end_check = 1'b0;
      unique case (mode_ff)
         M_WS: begin
            if (is_blank(c)) begin
               cb_in = sat_add(cb_ff, ONE);
               if (c == CH_LF) cn_in = sat_add(cn_ff, ONE);
               end_check = 1'b1;
            end else if (c == CH_SLASH && !last) begin
               tb_in   = ONE;
               tn_in   = '0;
               mode_in = M_SLASH;
            end else if (c == CH_BSL && !last && cfg.continuation_enable) begin
               tb_in   = ONE;
               tn_in   = '0;
               mode_in = M_BSL;
            end else begin
               emit = 1'b1;
            end
         end
         M_SLASH: begin
            if (c == CH_SLASH && cfg.line_comment_enable) begin
               cb_in     = sat_add(cb_ff, TWO);
               cn_in     = sat_add(cn_ff, tn_ff);
               tb_in     = '0;
               tn_in     = '0;
               mode_in   = M_LINE;
               end_check = 1'b1;
            end else if (c == CH_STAR && cfg.block_comment_enable) begin
               tb_in     = TWO;
               mode_in   = M_BLOCK;
               end_check = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         M_LINE: begin
            cb_in = sat_add(cb_ff, ONE);
            if (c == CH_LF) begin
               cn_in   = sat_add(cn_ff, ONE);
               mode_in = M_WS;
            end
            end_check = 1'b1;
         end
         M_BLOCK, M_BSTAR: begin
            end_check = 1'b1;
            if (mode_ff == M_BSTAR && c == CH_SLASH) begin
               cb_in   = sat_add(cb_ff, tb_inc);
               cn_in   = sat_add(cn_ff, tn_ff);
               tb_in   = '0;
               tn_in   = '0;
               mode_in = M_WS;
            end else begin
               tb_in = tb_inc;
               if (c == CH_LF) tn_in = sat_add(tn_ff, ONE);
               mode_in = (c == CH_STAR) ? M_BSTAR : M_BLOCK;
            end
         end
         M_BSL: begin
            if (c == CH_LF) begin
               cb_in     = sat_add(cb_ff, TWO);
               cn_in     = sat_add(cn_ff, ONE);
               tb_in     = '0;
               tn_in     = '0;
               mode_in   = M_WS;
               end_check = 1'b1;
            end else if (c == CH_CR && !last) begin
               tb_in   = TWO;
               mode_in = M_BSLCR;
            end else begin
               emit = 1'b1;
            end
         end
         M_BSLCR: begin
            if (c == CH_LF) begin
               cb_in     = sat_add(cb_ff, THREE);
               cn_in     = sat_add(cn_ff, ONE);
               tb_in     = '0;
               tn_in     = '0;
               mode_in   = M_WS;
               end_check = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         M_DISCARD: begin
            if (last) begin
               mode_in = M_WS;
               cb_in   = '0;
               cn_in   = '0;
               tb_in   = '0;
               tn_in   = '0;
            end
         end
         default: begin
            mode_in = M_WS;
            cb_in   = '0;
            cn_in   = '0;
            tb_in   = '0;
            tn_in   = '0;
         end
      endcase

      // buffer end drops any pending sequence
      if (end_check && last) begin
         tb_in = '0;
         tn_in = '0;
         emit  = 1'b1;
      end

      result.valid              = step && emit;
      result.data.skipped_count = to_out(cb_in);
      result.data.line_count    = to_out(cn_in);

      if (emit) begin
         tb_in = '0;
         tn_in = '0;
         if (last) begin
            mode_in = M_WS;
            cb_in   = '0;
            cn_in   = '0;
         end else begin
            mode_in = M_DISCARD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_WS;
         cb_ff   <= '0;
         cn_ff   <= '0;
         tb_ff   <= '0;
         tn_ff   <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         cb_ff   <= cb_in;
         cn_ff   <= cn_in;
         tb_ff   <= tb_in;
         tn_ff   <= tn_in;
      end
   end

endmodule

`default_nettype wire

@@ src/csw_out_stage.sv @@
// result register holding one item until the consumer takes it
// depends on csw_pkg
`default_nettype none

module csw_out_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire csw_pkg::result_type result,
   output logic                     drain,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output csw_pkg::rsp_type         rsp_data
);
   import csw_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign drain     = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (drain) begin
         valid_in = result.valid;
         data_in  = result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

@@ src/csw_checker.sv @@
// port-level checks for the comment and whitespace skipper, bound to the top level
// depends on csw_pkg and comment_whitespace_skipper_unit
`default_nettype none

module csw_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire csw_pkg::rsp_type rsp_data
);
   import csw_pkg::*;

   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_lines_within_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.line_count <= rsp_data.skipped_count))
      else $error("more newlines than skipped bytes");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

endmodule

bind comment_whitespace_skipper_unit csw_checker u_csw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
